[rtl/cbar_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbar_pkg: shared types and constants of the checkpoint rendezvous barrier
// Opcodes, slot index width, the chain's lookup record and the slot update.
// ----------------------------------------------------------------------------
package cbar_pkg;

    localparam int MAX_PARTICIPANTS_DEF = 16;
    localparam int NUM_CPUS_DEF         = 8;
    // slot index width covers the largest supported slot count (64)
    localparam int SLOT_W               = 6;

    typedef enum logic [3:0] {
        OP_BEGIN_START  = 4'd0,
        OP_ADD_ENTRY    = 4'd1,
        OP_BEGIN_COMMIT = 4'd2,
        OP_ARRIVE       = 4'd3,
        OP_SWITCH_OUT   = 4'd4,
        OP_QUIESCE_ACK  = 4'd5,
        OP_REJECT       = 4'd6,
        OP_TIMEOUT      = 4'd7,
        OP_RELEASE      = 4'd8,
        OP_READ_ENTRY   = 4'd9
    } op_t;

    localparam logic [3:0] REJ_NONE       = 4'd0;
    localparam logic [3:0] REJ_TOPOLOGY   = 4'd1;
    localparam logic [3:0] REJ_BAD_PC     = 4'd2;
    localparam logic [3:0] REJ_UNEXP_SAFE = 4'd3;
    localparam logic [3:0] REJ_DUPLICATE  = 4'd4;
    localparam logic [3:0] REJ_UNEXP_SW   = 4'd5;
    localparam logic [3:0] REJ_TIMEOUT    = 4'd6;

    // lookup request and the results it gathers on its way down the chain
    typedef struct packed {
        logic              valid;
        logic [31:0]       thread;
        logic [SLOT_W-1:0] rd_idx;
        logic              dup;
        logic              found;
        logic [SLOT_W-1:0] f_idx;
        logic [2:0]        f_cpu;
        logic              f_arr;
        logic              f_sw;
        logic [1:0]        notq_cnt;
        logic              any_run;
        logic              rd_hit;
        logic [31:0]       rd_thread;
        logic [2:0]        rd_cpu;
        logic [31:0]       rd_pc;
        logic              rd_run;
        logic              rd_arr;
        logic              rd_sw;
    } pass_t;

    // slot update broadcast from the controller
    typedef struct packed {
        logic              add;
        logic              arrive;
        logic              switch_out;
        logic              clear;
        logic [SLOT_W-1:0] idx;
        logic [31:0]       thread;
        logic [2:0]        cpu;
        logic              running;
        logic [31:0]       pc;
    } cmd_t;

endpackage
`default_nettype wire

[rtl/checkpoint_rendezvous_barrier.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// checkpoint_rendezvous_barrier: multi-cpu checkpoint barrier
// Begin sequence loads participants; active barrier tracks the rendezvous.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every request, of
// any opcode, runs one lookup down a chain of MAX_PARTICIPANTS slot cells,
// one cell per cycle. busy is high while the lookup runs; done follows in the
// next cycle, and busy is already low then, so the next request can be taken
// in the done cycle. done is high for a single cycle and the result is then
// on the result ports, where it holds until the next lookup finishes; there
// is no way to stall it, so capture it then. generation_out, barrier_active,
// rejection and quiesced_mask_out also show the live state.
// ----------------------------------------------------------------------------
module checkpoint_rendezvous_barrier #(
    parameter int MAX_PARTICIPANTS = cbar_pkg::MAX_PARTICIPANTS_DEF,
    parameter int NUM_CPUS         = cbar_pkg::NUM_CPUS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    output logic             done,
    input  wire logic [3:0]  op,
    input  wire logic [7:0]  dispatch_mask,
    input  wire logic [31:0] thread_ident,
    input  wire logic [3:0]  cpu_number,
    input  wire logic        is_running,
    input  wire logic [31:0] guest_pc_in,
    input  wire logic [3:0]  reject_code,
    input  wire logic [3:0]  entry_index,
    output logic             accepted,
    output logic             barrier_active,
    output logic [3:0]       rejection,
    output logic             is_quiesced,
    output logic [63:0]      generation_out,
    output logic [7:0]       quiesced_mask_out,
    output logic [31:0]      entry_thread,
    output logic [2:0]       entry_cpu,
    output logic [31:0]      entry_pc,
    output logic             entry_running,
    output logic             entry_arrived,
    output logic             entry_switched
);

    localparam int CNT_W = $clog2(MAX_PARTICIPANTS + 1);
    localparam int SW    = cbar_pkg::SLOT_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t state_reg, state_next;

    // barrier state
    logic             active_reg, active_next;
    logic             loading_reg, loading_next;
    logic             failed_reg, failed_next;
    logic [3:0]       rej_reg, rej_next;
    logic [63:0]      gen_reg, gen_next;
    logic [7:0]       disp_reg, disp_next;
    logic [7:0]       qcpu_reg, qcpu_next;
    logic [7:0]       seen_reg, seen_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // latched request
    logic [3:0]  req_op_reg;
    logic [7:0]  req_mask_reg;
    logic [31:0] req_thread_reg;
    logic [3:0]  req_cpu_reg;
    logic        req_run_reg;
    logic [31:0] req_pc_reg;
    logic [3:0]  req_code_reg;

    // result registers
    logic        done_reg;
    logic        acc_reg, acc_next;
    logic        quies_reg, quies_next;
    logic [31:0] e_thread_reg, e_thread_next;
    logic [2:0]  e_cpu_reg, e_cpu_next;
    logic [31:0] e_pc_reg, e_pc_next;
    logic        e_run_reg, e_run_next;
    logic        e_arr_reg, e_arr_next;
    logic        e_sw_reg, e_sw_next;

    logic            launch;
    logic            finish;
    cbar_pkg::pass_t chain [0:MAX_PARTICIPANTS];
    cbar_pkg::pass_t r;
    cbar_pkg::cmd_t  cmd;
    logic            cpu_ok;
    logic [7:0]      cpu_bit;
    logic            notq_after;

    assign busy   = (state_reg != ST_IDLE);
    assign launch = start && !busy;
    assign r      = chain[MAX_PARTICIPANTS];
    assign finish = (state_reg == ST_SCAN) && r.valid;

    // feed the lookup into the first cell
    always_comb
    begin
        chain[0]        = '0;
        chain[0].valid  = launch;
        chain[0].thread = thread_ident;
        chain[0].rd_idx = {{(SW - 4){1'b0}}, entry_index};
    end

    generate
        for (genvar i = 0; i < MAX_PARTICIPANTS; i++)
        begin : g_cell
            cbar_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .my_idx   (SW'(i)),
                .in_range (count_reg > CNT_W'(i)),
                .pass_in  (chain[i]),
                .cmd      (cmd),
                .pass_out (chain[i + 1])
            );
        end
    endgenerate

    assign cpu_ok  = ({1'b0, req_cpu_reg} < 5'(NUM_CPUS));
    assign cpu_bit = 8'(9'd1 << req_cpu_reg[2:0]);

    // resolve the request once the lookup leaves the last cell
    always_comb
    begin
        state_next    = state_reg;
        active_next   = active_reg;
        loading_next  = loading_reg;
        failed_next   = failed_reg;
        rej_next      = rej_reg;
        gen_next      = gen_reg;
        disp_next     = disp_reg;
        qcpu_next     = qcpu_reg;
        seen_next     = seen_reg;
        count_next    = count_reg;
        acc_next      = 1'b0;
        e_thread_next = 32'd0;
        e_cpu_next    = 3'd0;
        e_pc_next     = 32'd0;
        e_run_next    = 1'b0;
        e_arr_next    = 1'b0;
        e_sw_next     = 1'b0;
        notq_after    = (r.notq_cnt != 2'd0);
        cmd           = '0;
        cmd.thread    = req_thread_reg;
        cmd.cpu       = req_cpu_reg[2:0];
        cmd.running   = req_run_reg;
        cmd.pc        = req_pc_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (launch)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (r.valid)
                begin
                    state_next = ST_IDLE;
                    unique case (req_op_reg)
                        cbar_pkg::OP_BEGIN_START:
                        begin
                            if (!active_reg)
                            begin
                                if (req_mask_reg == 8'd0)
                                begin
                                    rej_next     = cbar_pkg::REJ_TOPOLOGY;
                                    loading_next = 1'b0;
                                end
                                else
                                begin
                                    loading_next = 1'b1;
                                    failed_next  = 1'b0;
                                    seen_next    = 8'd0;
                                    count_next   = '0;
                                    disp_next    = req_mask_reg;
                                    acc_next     = 1'b1;
                                end
                            end
                        end
                        cbar_pkg::OP_ADD_ENTRY:
                        begin
                            if (!active_reg && loading_reg && !failed_reg)
                            begin
                                if ((req_thread_reg != 32'd0) && cpu_ok
                                    && ((disp_reg & cpu_bit) != 8'd0) && !r.dup
                                    && !(req_run_reg && ((seen_reg & cpu_bit) != 8'd0))
                                    && (count_reg < CNT_W'(MAX_PARTICIPANTS)))
                                begin
                                    if (req_run_reg)
                                    begin
                                        seen_next = seen_reg | cpu_bit;
                                    end
                                    cmd.add    = 1'b1;
                                    cmd.idx    = SW'(count_reg);
                                    count_next = count_reg + CNT_W'(1);
                                    acc_next   = 1'b1;
                                end
                                else
                                begin
                                    failed_next = 1'b1;
                                end
                            end
                        end
                        cbar_pkg::OP_BEGIN_COMMIT:
                        begin
                            if (!active_reg && loading_reg)
                            begin
                                loading_next = 1'b0;
                                if (failed_reg || (gen_reg == {64{1'b1}}))
                                begin
                                    rej_next = cbar_pkg::REJ_TOPOLOGY;
                                end
                                else
                                begin
                                    gen_next    = gen_reg + 64'd1;
                                    rej_next    = cbar_pkg::REJ_NONE;
                                    qcpu_next   = 8'd0;
                                    cmd.clear   = 1'b1;
                                    active_next = 1'b1;
                                    acc_next    = 1'b1;
                                    notq_after  = r.any_run;
                                end
                            end
                        end
                        cbar_pkg::OP_ARRIVE:
                        begin
                            if (active_reg && (rej_reg == cbar_pkg::REJ_NONE))
                            begin
                                if ((req_pc_reg == 32'd0) || (req_pc_reg[1:0] != 2'd0)
                                    || !cpu_ok)
                                begin
                                    rej_next = cbar_pkg::REJ_BAD_PC;
                                end
                                else if (!r.found || ({1'b0, r.f_cpu} != req_cpu_reg))
                                begin
                                    rej_next = cbar_pkg::REJ_UNEXP_SAFE;
                                end
                                else if (r.f_arr)
                                begin
                                    rej_next = cbar_pkg::REJ_DUPLICATE;
                                end
                                else
                                begin
                                    cmd.arrive = 1'b1;
                                    cmd.idx    = r.f_idx;
                                    acc_next   = 1'b1;
                                end
                            end
                        end
                        cbar_pkg::OP_SWITCH_OUT:
                        begin
                            if (active_reg)
                            begin
                                if (!r.found || ({1'b0, r.f_cpu} != req_cpu_reg)
                                    || !r.f_arr || r.f_sw)
                                begin
                                    if (rej_reg == cbar_pkg::REJ_NONE)
                                    begin
                                        rej_next = cbar_pkg::REJ_UNEXP_SW;
                                    end
                                end
                                else
                                begin
                                    cmd.switch_out = 1'b1;
                                    cmd.idx        = r.f_idx;
                                    acc_next       = 1'b1;
                                    // the switched slot no longer holds quiesce off
                                    notq_after     = (r.notq_cnt == 2'd2);
                                end
                            end
                        end
                        cbar_pkg::OP_QUIESCE_ACK:
                        begin
                            if (active_reg && cpu_ok)
                            begin
                                if ((disp_reg & cpu_bit) == 8'd0)
                                begin
                                    rej_next = cbar_pkg::REJ_TOPOLOGY;
                                end
                                else
                                begin
                                    qcpu_next = qcpu_reg | cpu_bit;
                                    acc_next  = 1'b1;
                                end
                            end
                        end
                        cbar_pkg::OP_REJECT:
                        begin
                            if (active_reg && (req_code_reg != 4'd0)
                                && (rej_reg == cbar_pkg::REJ_NONE))
                            begin
                                rej_next = req_code_reg;
                                acc_next = 1'b1;
                            end
                        end
                        cbar_pkg::OP_TIMEOUT:
                        begin
                            if (active_reg)
                            begin
                                if ((rej_reg == cbar_pkg::REJ_NONE)
                                    && !(((qcpu_reg & disp_reg) == disp_reg)
                                         && (r.notq_cnt == 2'd0)))
                                begin
                                    rej_next = cbar_pkg::REJ_TIMEOUT;
                                end
                                else
                                begin
                                    acc_next = (rej_reg == cbar_pkg::REJ_NONE)
                                               && ((qcpu_reg & disp_reg) == disp_reg)
                                               && (r.notq_cnt == 2'd0);
                                end
                            end
                        end
                        cbar_pkg::OP_RELEASE:
                        begin
                            if (active_reg)
                            begin
                                active_next = 1'b0;
                                acc_next    = 1'b1;
                            end
                        end
                        cbar_pkg::OP_READ_ENTRY:
                        begin
                            if (r.rd_hit)
                            begin
                                e_thread_next = r.rd_thread;
                                e_cpu_next    = r.rd_cpu;
                                e_pc_next     = r.rd_pc;
                                e_run_next    = r.rd_run;
                                e_arr_next    = r.rd_arr;
                                e_sw_next     = r.rd_sw;
                                acc_next      = 1'b1;
                            end
                        end
                        default:
                        begin
                            // unused opcodes: drop
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        quies_next = active_next && ((qcpu_next & disp_next) == disp_next) && !notq_after;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            active_reg  <= 1'b0;
            loading_reg <= 1'b0;
            failed_reg  <= 1'b0;
            rej_reg     <= cbar_pkg::REJ_NONE;
            gen_reg     <= 64'd0;
            disp_reg    <= 8'd0;
            qcpu_reg    <= 8'd0;
            seen_reg    <= 8'd0;
            count_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            loading_reg <= loading_next;
            failed_reg  <= failed_next;
            rej_reg     <= rej_next;
            gen_reg     <= gen_next;
            disp_reg    <= disp_next;
            qcpu_reg    <= qcpu_next;
            seen_reg    <= seen_next;
            count_reg   <= count_next;
            done_reg    <= finish;
        end
    end

    // hold the request while the lookup runs
    always_ff @(posedge clk)
    begin
        if (launch)
        begin
            req_op_reg     <= op;
            req_mask_reg   <= dispatch_mask;
            req_thread_reg <= thread_ident;
            req_cpu_reg    <= cpu_number;
            req_run_reg    <= is_running;
            req_pc_reg     <= guest_pc_in;
            req_code_reg   <= reject_code;
        end
        if (finish)
        begin
            acc_reg      <= acc_next;
            quies_reg    <= quies_next;
            e_thread_reg <= e_thread_next;
            e_cpu_reg    <= e_cpu_next;
            e_pc_reg     <= e_pc_next;
            e_run_reg    <= e_run_next;
            e_arr_reg    <= e_arr_next;
            e_sw_reg     <= e_sw_next;
        end
    end

    assign done              = done_reg;
    assign accepted          = acc_reg;
    assign barrier_active    = active_reg;
    assign rejection         = rej_reg;
    assign is_quiesced       = quies_reg;
    assign generation_out    = gen_reg;
    assign quiesced_mask_out = qcpu_reg;
    assign entry_thread      = e_thread_reg;
    assign entry_cpu         = e_cpu_reg;
    assign entry_pc          = e_pc_reg;
    assign entry_running     = e_run_reg;
    assign entry_arrived     = e_arr_reg;
    assign entry_switched    = e_sw_reg;

    a_done_after_scan : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_SCAN))
        else $error("result strobe without a finished lookup");

    a_quiesced_active : assert property (@(posedge clk) disable iff (!rst_n)
        done && is_quiesced |-> barrier_active)
        else $error("quiesced reported while inactive");

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_PARTICIPANTS))
        else $error("entry count beyond slot count");

    a_active_no_load : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(active_reg) |-> !loading_reg)
        else $error("barrier activated with a load still open");

endmodule
`default_nettype wire

[rtl/cbar_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbar_cell: one participant slot of the barrier chain
// Holds a slot, folds it into the passing lookup and applies slot updates.
// ----------------------------------------------------------------------------
module cbar_cell (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [cbar_pkg::SLOT_W-1:0] my_idx,
    input  wire logic                        in_range,
    input  wire cbar_pkg::pass_t             pass_in,
    input  wire cbar_pkg::cmd_t              cmd,
    output cbar_pkg::pass_t                  pass_out
);

    logic [31:0]     thread_reg;
    logic [2:0]      cpu_reg;
    logic            running_reg;
    logic [31:0]     pc_reg;
    logic            arrived_reg;
    logic            switched_reg;
    cbar_pkg::pass_t pass_reg;
    cbar_pkg::pass_t pass_next;
    logic            hit;
    logic            match;
    logic            sel;

    assign hit   = in_range && pass_in.valid;
    assign match = hit && (thread_reg == pass_in.thread);
    assign sel   = (cmd.idx == my_idx);

    always_comb
    begin
        pass_next = pass_in;
        if (match)
        begin
            pass_next.dup = 1'b1;
        end
        // keep the first running slot of this thread
        if (match && running_reg && !pass_in.found)
        begin
            pass_next.found = 1'b1;
            pass_next.f_idx = my_idx;
            pass_next.f_cpu = cpu_reg;
            pass_next.f_arr = arrived_reg;
            pass_next.f_sw  = switched_reg;
        end
        if (hit && running_reg)
        begin
            pass_next.any_run = 1'b1;
            if (!switched_reg)
            begin
                pass_next.notq_cnt = (pass_in.notq_cnt == 2'd0) ? 2'd1 : 2'd2;
            end
        end
        if (hit && (pass_in.rd_idx == my_idx))
        begin
            pass_next.rd_hit    = 1'b1;
            pass_next.rd_thread = thread_reg;
            pass_next.rd_cpu    = cpu_reg;
            pass_next.rd_pc     = pc_reg;
            pass_next.rd_run    = running_reg;
            pass_next.rd_arr    = arrived_reg;
            pass_next.rd_sw     = switched_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_reg <= '0;
        end
        else
        begin
            pass_reg <= pass_next;
        end
    end

    // slot storage: add loads a fresh entry, commit clears the flags, arrive and switch-out set them
    always_ff @(posedge clk)
    begin
        if (cmd.add && sel)
        begin
            thread_reg   <= cmd.thread;
            cpu_reg      <= cmd.cpu;
            running_reg  <= cmd.running;
            pc_reg       <= 32'd0;
            arrived_reg  <= 1'b0;
            switched_reg <= 1'b0;
        end
        else if (cmd.clear)
        begin
            arrived_reg  <= 1'b0;
            switched_reg <= 1'b0;
        end
        else if (cmd.arrive && sel)
        begin
            pc_reg      <= cmd.pc;
            arrived_reg <= 1'b1;
        end
        else if (cmd.switch_out && sel)
        begin
            switched_reg <= 1'b1;
        end
    end

    assign pass_out = pass_reg;

endmodule
`default_nettype wire
